/* sv/ssm_pkg.sv */
// Shared constants, types and helpers for the slot encoder speed meter.
package ssm_pkg;

  localparam int WINDOW_DEPTH = 16;

  localparam int NUM_W     = 52;
  localparam int DEN_W     = 48;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [35:0] VEL_NUM   = 36'd46080000000;
  localparam logic [19:0] ACC_SCALE = 20'd1000000;

  localparam logic [7:0]  SLOTS_RST    = 8'd20;
  localparam logic [15:0] DEBOUNCE_RST = 16'd500;
  localparam logic [31:0] TIMEOUT_RST  = 32'd1000000;
  localparam logic [15:0] PERIOD_RST   = 16'd100;

  localparam logic [3:0] REG_SLOTS    = 4'd0;
  localparam logic [3:0] REG_DEBOUNCE = 4'd1;
  localparam logic [3:0] REG_TIMEOUT  = 4'd2;
  localparam logic [3:0] REG_PERIOD   = 4'd3;

  typedef struct packed {
    logic capture;
    logic eval;
    logic load_inst;
    logic load_avg;
    logic load_acc;
    logic wr_inst;
    logic wr_avg;
    logic wr_acc;
    logic write_out;
  } ssm_cmd_t;

  typedef struct packed {
    logic timeout;
    logic step;
    logic sample;
    logic div_done;
    logic out_free;
  } ssm_status_t;

  function automatic logic [31:0] sat32(input logic [NUM_W-1:0] q);
    return (|q[NUM_W-1:32]) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

endpackage

/* sv/ssm_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module ssm_div
  import ssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   r_sh;
  logic             ge;
  logic [DEN_W:0]   diff;

  assign r_sh = {rem, quot[NUM_W-1]};
  assign ge   = r_sh >= {1'b0, den_r};
  assign diff = r_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");

endmodule

/* sv/ssm_ctrl.sv */
// Sequencing controller for one poll request.
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ssm_status_t status,
  output ssm_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_LD1  = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_LD2  = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;
  localparam logic [3:0] S_LD3  = 4'd6;
  localparam logic [3:0] S_W3   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = (!status.timeout && status.step) ? S_LD1 : S_FIN;
      end
      S_LD1: begin
        cmd.load_inst = 1'b1;
        state_next    = S_W1;
      end
      S_W1: begin
        if (status.div_done) begin
          cmd.wr_inst = 1'b1;
          state_next  = status.sample ? S_LD2 : S_FIN;
        end
      end
      S_LD2: begin
        cmd.load_avg = 1'b1;
        state_next   = S_W2;
      end
      S_W2: begin
        if (status.div_done) begin
          cmd.wr_avg = 1'b1;
          state_next = S_LD3;
        end
      end
      S_LD3: begin
        cmd.load_acc = 1'b1;
        state_next   = S_W3;
      end
      S_W3: begin
        if (status.div_done) begin
          cmd.wr_acc = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/ssm_datapath.sv */
// Measurement state, configuration, divider operands and result register.
module ssm_datapath
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ssm_cmd_t    cmd,
  output ssm_status_t status,
  input  logic        cfg_valid,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [31:0] now_us,
  input  logic [31:0] now_ms,
  input  logic        edge_seen,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        step_taken,
  output logic        sample_done,
  output logic        timed_out,
  output logic [31:0] total_steps,
  output logic [6:0]  window_steps,
  output logic [31:0] instant_velocity,
  output logic [31:0] average_velocity,
  output logic signed [39:0] acceleration
);

  logic [7:0]  slots_per_rev;
  logic [15:0] debounce_min_us;
  logic [31:0] timeout_us;
  logic [15:0] update_period_ms;

  logic [31:0] now_us_r;
  logic [31:0] now_ms_r;
  logic        edge_r;

  logic [31:0] last_step_time;
  logic [31:0] step_count;
  logic [6:0]  window_count;
  logic [39:0] window_sum;
  logic [39:0] prev_window_sum;
  logic [6:0]  last_window_steps;
  logic [31:0] avg_velocity_reg;
  logic [39:0] accel_reg;
  logic [31:0] inst_velocity_reg;
  logic [31:0] next_update_time;
  logic        edge_pending;
  logic [31:0] delta_r;
  logic [31:0] vold;
  logic        step_r;
  logic        sample_r;
  logic        tout_r;

  logic [31:0]      delta;
  logic             tout;
  logic             edge_any;
  logic             step;
  logic [6:0]       wc_inc;
  logic [7:0]       slots_eff;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic             neg;
  logic [31:0]      mag;
  logic [40:0]      acc_den;
  logic [31:0]      next_time;

  assign delta     = now_us_r - last_step_time;
  assign tout      = delta > timeout_us;
  assign edge_any  = edge_r | edge_pending;
  assign step      = !tout && edge_any && (delta > {16'd0, debounce_min_us});
  assign wc_inc    = window_count + 7'd1;
  assign slots_eff = (slots_per_rev == 8'd0) ? 8'd1 : slots_per_rev;
  assign neg       = avg_velocity_reg < vold;
  assign mag       = neg ? (vold - avg_velocity_reg) : (avg_velocity_reg - vold);
  assign acc_den   = {1'b0, window_sum} + {1'b0, prev_window_sum};
  assign next_time = now_ms_r + {16'd0, update_period_ms};

  assign status.timeout  = tout;
  assign status.step     = step;
  assign status.sample   = sample_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  // Operand select: each product lands in the divider's input registers.
  always_comb begin
    div_start = cmd.load_inst | cmd.load_avg | cmd.load_acc;
    div_num   = '0;
    div_den   = '0;
    if (cmd.load_inst) begin
      div_num = NUM_W'(VEL_NUM);
      div_den = DEN_W'(slots_eff * delta_r);
    end else if (cmd.load_avg) begin
      div_num = NUM_W'(VEL_NUM * window_count);
      div_den = DEN_W'(slots_eff * window_sum);
    end else if (cmd.load_acc) begin
      div_num = NUM_W'(mag * ACC_SCALE);
      div_den = (acc_den == 41'd0) ? DEN_W'(1) : DEN_W'(acc_den);
    end
  end

  ssm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_rev    <= SLOTS_RST;
      debounce_min_us  <= DEBOUNCE_RST;
      timeout_us       <= TIMEOUT_RST;
      update_period_ms <= PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOTS:    slots_per_rev    <= cfg_data[7:0];
        REG_DEBOUNCE: debounce_min_us  <= cfg_data[15:0];
        REG_TIMEOUT:  timeout_us       <= cfg_data;
        REG_PERIOD:   update_period_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_us_r <= now_us;
      now_ms_r <= now_ms;
      edge_r   <= edge_seen;
    end
    if (cmd.eval) begin
      delta_r <= delta;
    end
    if (cmd.wr_avg) begin
      vold <= avg_velocity_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_step_time    <= '0;
      step_count        <= '0;
      window_count      <= '0;
      window_sum        <= '0;
      prev_window_sum   <= '0;
      last_window_steps <= '0;
      avg_velocity_reg  <= '0;
      accel_reg         <= '0;
      inst_velocity_reg <= '0;
      next_update_time  <= {16'd0, PERIOD_RST};
      edge_pending      <= 1'b0;
      step_r            <= 1'b0;
      sample_r          <= 1'b0;
      tout_r            <= 1'b0;
    end else begin
      if (cmd.eval) begin
        tout_r   <= tout;
        step_r   <= step;
        sample_r <= step && ((wc_inc >= 7'(WINDOW_DEPTH)) || (now_ms_r >= next_update_time));
        if (tout) begin
          last_step_time    <= now_us_r;
          step_count        <= '0;
          window_count      <= '0;
          window_sum        <= '0;
          prev_window_sum   <= '0;
          last_window_steps <= '0;
          avg_velocity_reg  <= '0;
          accel_reg         <= '0;
          inst_velocity_reg <= '0;
          next_update_time  <= next_time;
          edge_pending      <= edge_any;
        end else begin
          edge_pending <= 1'b0;
          if (step) begin
            step_count     <= step_count + 32'd1;
            last_step_time <= now_us_r;
            window_count   <= wc_inc;
            window_sum     <= window_sum + {8'd0, delta};
          end
        end
      end
      if (cmd.wr_inst) begin
        inst_velocity_reg <= sat32(quot);
      end
      if (cmd.wr_avg) begin
        avg_velocity_reg <= sat32(quot);
      end
      if (cmd.wr_acc) begin
        if (neg) begin
          accel_reg <= (|quot[NUM_W-1:39]) ? 40'h80_0000_0000 : (40'd0 - quot[39:0]);
        end else begin
          accel_reg <= (|quot[NUM_W-1:39]) ? 40'h7F_FFFF_FFFF : quot[39:0];
        end
        prev_window_sum   <= window_sum;
        last_window_steps <= window_count;
        window_count      <= '0;
        window_sum        <= '0;
        next_update_time  <= next_time;
      end
    end
  end

  // Result register: holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      step_taken       <= step_r;
      sample_done      <= sample_r;
      timed_out        <= tout_r;
      total_steps      <= step_count;
      window_steps     <= last_window_steps;
      instant_velocity <= inst_velocity_reg;
      average_velocity <= avg_velocity_reg;
      acceleration     <= accel_reg;
    end
  end

  a_flags_excl: assert property (@(posedge clk) disable iff (rst) !(tout_r && step_r))
    else $error("timeout and step flagged together");
  a_sample_step: assert property (@(posedge clk) disable iff (rst) sample_r |-> step_r)
    else $error("sample without step");
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
      window_count <= 7'(WINDOW_DEPTH))
    else $error("window count overrun");

endmodule

/* sv/slot_encoder_speed_meter.sv */
// Top level of the slot encoder speed meter.
//
// Poll channel (in_valid/in_ready): each request carries now_us, now_ms and
// edge_seen. One result request leaves on out_valid/out_ready for every poll.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 slots_per_rev, 1 debounce_min_us, 2 timeout_us, 3 update_period_ms;
// other indexes are dropped. Write config only while no poll is in flight.
// A poll without a step is captured, evaluated and then written to the result
// register. A step runs one pass of the shared divider (instant velocity); a
// step that closes a window runs three passes (instant velocity, then average
// velocity, then acceleration). The next poll is accepted in the cycle after
// the result is written. The iterative divider, one quotient bit per cycle,
// sets the rate; one poll is worked on at a time.
// The result register parts the sides: a new poll is accepted while an
// earlier result still waits; a finished poll holds until the register frees.
// Reset (rst, synchronous) clears all measurement state, loads the default
// config and sets the next update time to the default period.
module slot_encoder_speed_meter
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] now_us,
  input  logic [31:0] now_ms,
  input  logic        edge_seen,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        step_taken,
  output logic        sample_done,
  output logic        timed_out,
  output logic [31:0] total_steps,
  output logic [6:0]  window_steps,
  output logic [31:0] instant_velocity,
  output logic [31:0] average_velocity,
  output logic signed [39:0] acceleration,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ssm_cmd_t    cmd;
  ssm_status_t status;

  // Config writes are always accepted and never stalled.
  assign cfg_ready = 1'b1;

  ssm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssm_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .now_us           (now_us),
    .now_ms           (now_ms),
    .edge_seen        (edge_seen),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .step_taken       (step_taken),
    .sample_done      (sample_done),
    .timed_out        (timed_out),
    .total_steps      (total_steps),
    .window_steps     (window_steps),
    .instant_velocity (instant_velocity),
    .average_velocity (average_velocity),
    .acceleration     (acceleration)
  );

endmodule

/* verif/tb_slot_encoder_speed_meter.sv */
// Regression testbench for the slot encoder speed meter: directed and random polls.
`timescale 1ns / 100ps

module tb_slot_encoder_speed_meter
  import ssm_pkg::*;
();

  // One expected result request.
  typedef struct {
    logic        step_taken;
    logic        sample_done;
    logic        timed_out;
    logic [31:0] total_steps;
    logic [6:0]  window_steps;
    logic [31:0] instant_velocity;
    logic [31:0] average_velocity;
    logic [39:0] acceleration;
  } speed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] now_us = '0;
  logic [31:0] now_ms = '0;
  logic        edge_seen = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        step_taken;
  logic        sample_done;
  logic        timed_out;
  logic [31:0] total_steps;
  logic [6:0]  window_steps;
  logic [31:0] instant_velocity;
  logic [31:0] average_velocity;
  logic signed [39:0] acceleration;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  slot_encoder_speed_meter DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .now_us           (now_us),
    .now_ms           (now_ms),
    .edge_seen        (edge_seen),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .step_taken       (step_taken),
    .sample_done      (sample_done),
    .timed_out        (timed_out),
    .total_steps      (total_steps),
    .window_steps     (window_steps),
    .instant_velocity (instant_velocity),
    .average_velocity (average_velocity),
    .acceleration     (acceleration),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: the configuration and the measurement registers.
  logic [7:0]  cfg_slots;
  logic [15:0] cfg_debounce;
  logic [31:0] cfg_timeout;
  logic [15:0] cfg_period;

  logic [31:0] last_step_us;
  logic [31:0] step_cnt;
  logic [6:0]  win_cnt;
  logic [39:0] win_sum;
  logic [39:0] prev_win_sum;
  logic [6:0]  last_win_steps;
  logic [31:0] avg_vel;
  logic [39:0] accel_val;
  logic [31:0] inst_vel;
  logic [31:0] next_update_ms;
  logic        held_edge;

  speed_result_t expected_results[$];
  int  fail_count = 0;
  bit  hold_off = 1'b0;    // long receiver stall requested by a test
  // Free-running clocks of the modeled system, advanced by the tests.
  logic [31:0] clock_us = '0;
  logic [31:0] clock_ms = '0;

  localparam logic [39:0] ACC_POS_LIMIT = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] ACC_NEG_LIMIT = 40'h80_0000_0000;
  localparam logic [3:0]  REG_UNUSED    = 4'd9;

  function automatic logic [31:0] sat_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = num / den;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [39:0] accel_from(logic [31:0] vnew, logic [31:0] vold,
                                             logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    if (den == 0) den = 1;
    if (vnew < vold) begin
      mag = vold - vnew;
      q = (mag * 64'd1000000) / den;
      if (q > {24'd0, ACC_NEG_LIMIT}) q = {24'd0, ACC_NEG_LIMIT};
      return 40'(64'd0 - q);
    end
    mag = vnew - vold;
    q = (mag * 64'd1000000) / den;
    if (q > {24'd0, ACC_POS_LIMIT}) q = {24'd0, ACC_POS_LIMIT};
    return q[39:0];
  endfunction

  task automatic clear_measurement(logic [31:0] us, logic [31:0] ms);
    last_step_us   = us;
    step_cnt       = '0;
    win_cnt        = '0;
    win_sum        = '0;
    prev_win_sum   = '0;
    last_win_steps = '0;
    avg_vel        = '0;
    accel_val      = '0;
    inst_vel       = '0;
    next_update_ms = ms + {16'd0, cfg_period};
  endtask

  // Advance the speed predictor by one poll and queue its result.
  task automatic predict_speed(logic [31:0] us, logic [31:0] ms, logic edge_in);
    speed_result_t r;
    logic [31:0] gap;
    logic [63:0] slots;
    logic [31:0] vold;
    logic [63:0] n;
    logic        fired;
    fired = edge_in | held_edge;
    gap   = us - last_step_us;
    slots = (cfg_slots == 0) ? 64'd1 : {56'd0, cfg_slots};
    r.step_taken  = 1'b0;
    r.sample_done = 1'b0;
    r.timed_out   = 1'b0;
    if (gap > cfg_timeout) begin
      clear_measurement(us, ms);
      held_edge   = fired;
      r.timed_out = 1'b1;
    end else begin
      held_edge = 1'b0;
      if (fired && gap > {16'd0, cfg_debounce}) begin
        r.step_taken = 1'b1;
        step_cnt++;
        inst_vel     = sat_quotient(64'd46080000000, slots * gap);
        last_step_us = us;
        win_cnt      = win_cnt + 7'd1;
        win_sum      = win_sum + {8'd0, gap};
        if (win_cnt >= WINDOW_DEPTH || ms >= next_update_ms) begin
          vold      = avg_vel;
          n         = (win_cnt == 0) ? 64'd1 : {57'd0, win_cnt};
          avg_vel   = sat_quotient(64'd46080000000 * n, slots * win_sum);
          accel_val = accel_from(avg_vel, vold, {24'd0, win_sum} + {24'd0, prev_win_sum});
          prev_win_sum   = win_sum;
          last_win_steps = win_cnt;
          win_cnt        = '0;
          win_sum        = '0;
          next_update_ms = ms + {16'd0, cfg_period};
          r.sample_done  = 1'b1;
        end
      end
    end
    r.total_steps      = step_cnt;
    r.window_steps     = last_win_steps;
    r.instant_velocity = inst_vel;
    r.average_velocity = avg_vel;
    r.acceleration     = accel_val;
    expected_results.push_back(r);
  endtask

  // Sender: random gaps between bursts; valid holds until accepted.
  int burst_left = 0;

  task automatic send_poll(logic [31:0] us, logic [31:0] ms, logic edge_in);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    burst_left--;
    predict_speed(us, ms, edge_in);
    in_valid  <= 1'b1;
    now_us    <= us;
    now_ms    <= ms;
    edge_seen <= edge_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    // The block is busy after accepting a request anyway.
    @(posedge clk);
  endtask

  // Advance the system clocks by dt microseconds and send a poll.
  task automatic poll_after(logic [31:0] dt, logic edge_in);
    clock_us = clock_us + dt;
    clock_ms = clock_ms + dt / 1000;
    send_poll(clock_us, clock_ms, edge_in);
  endtask

  // Wait for all results, then let the block finish any leftover work.
  task automatic drain;
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SLOTS:    cfg_slots    = value[7:0];
      REG_DEBOUNCE: cfg_debounce = value[15:0];
      REG_TIMEOUT:  cfg_timeout  = value;
      REG_PERIOD:   cfg_period   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] slots, logic [31:0] deb, logic [31:0] tmo,
                            logic [31:0] per);
    drain();
    write_reg(REG_SLOTS, slots);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_PERIOD, per);
  endtask

  // Receiver: stalls on its own pattern; hold_off forces a long stall.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 7) != 0) || (($urandom_range(0, 63) & 32) != 0);
    end
  end

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    speed_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (step_taken !== e.step_taken) begin
          $error("step_taken exp %0d got %0d", e.step_taken, step_taken); fail_count++;
        end
        if (sample_done !== e.sample_done) begin
          $error("sample_done exp %0d got %0d", e.sample_done, sample_done); fail_count++;
        end
        if (timed_out !== e.timed_out) begin
          $error("timed_out exp %0d got %0d", e.timed_out, timed_out); fail_count++;
        end
        if (total_steps !== e.total_steps) begin
          $error("total_steps exp %0d got %0d", e.total_steps, total_steps); fail_count++;
        end
        if (window_steps !== e.window_steps) begin
          $error("window_steps exp %0d got %0d", e.window_steps, window_steps);
          fail_count++;
        end
        if (instant_velocity !== e.instant_velocity) begin
          $error("instant_velocity exp %0d got %0d", e.instant_velocity,
                 instant_velocity);
          fail_count++;
        end
        if (average_velocity !== e.average_velocity) begin
          $error("average_velocity exp %0d got %0d", e.average_velocity,
                 average_velocity);
          fail_count++;
        end
        if (acceleration !== e.acceleration) begin
          $error("acceleration exp %0h got %0h", e.acceleration, acceleration);
          fail_count++;
        end
      end
    end
  end

  // Extremes of the fields, timeout with a held edge, debounce rejection.
  task automatic test_directed;
    send_poll(32'd0, 32'd0, 1'b1);               // no gap: debounced
    send_poll(32'd501, 32'd0, 1'b1);             // first step
    send_poll(32'd1001, 32'd0, 1'b1);            // exactly at debounce: drop
    send_poll(32'd1002, 32'd200, 1'b1);          // step closing by update time
    send_poll(32'd1003, 32'd200, 1'b0);
    send_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // timeout, edge held
    send_poll(32'd600, 32'hFFFF_FFFF, 1'b0);     // wrapped gap, held edge steps
    send_poll(32'd1200, 32'd0, 1'b0);
    send_poll(32'h5555_5555, 32'hAAAA_AAAA, 1'b0); // timeout
    send_poll(32'h5555_5A00, 32'h5555_5555, 1'b1);
    clock_us = 32'h5555_5A00;
    clock_ms = 32'h5555_5555;
  endtask

  // Steady rotation with jitter: fills the window and steps the speed up or down.
  task automatic test_rotation(int count, int base_dt, int jitter);
    int dt;
    for (int i = 0; i < count; i++) begin
      dt = base_dt + $urandom_range(0, jitter);
      if ($urandom_range(0, 3) == 0) poll_after($urandom_range(0, dt / 2), 1'b0);
      poll_after(dt, 1'b1);
      if (i % 10 == 9) base_dt = base_dt / 2 + $urandom_range(1, base_dt);
    end
  endtask

  // Random noise: odd times, timeouts, bouncing edges.
  task automatic test_noise(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: send_poll($urandom, $urandom, 1'($urandom_range(0, 1)));
        1: poll_after($urandom_range(0, 600), 1'b1);
        default: poll_after($urandom_range(1, 5000), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // Stall the receiver while polls keep coming so the input stalls too.
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      test_rotation(12, 800, 300);
    join
  endtask

  initial begin
    cfg_slots    = SLOTS_RST;
    cfg_debounce = DEBOUNCE_RST;
    cfg_timeout  = TIMEOUT_RST;
    cfg_period   = PERIOD_RST;
    clear_measurement(32'd0, 32'd0);
    held_edge = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_rotation(40, 2000, 500);
    test_backpressure();
    // Extremes: one slot, no debounce, short timeout, a 1 ms period.
    set_config(32'd1, 32'd0, 32'd3000, 32'd1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);        // unused index: dropped
    test_rotation(30, 50, 100);
    test_noise(40);
    // Zero slots, full-width values truncated by the register widths.
    set_config(32'hFFFF_FF00, 32'hFFFF_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_rotation(40, 3, 5);                     // very fast: velocity saturates
    test_noise(30);
    // Largest slots and debounce, tiny timeout.
    set_config(32'd255, 32'd65535, 32'd1, 32'd65535);
    test_noise(30);
    set_config(32'd255, 32'd65535, 32'd2000000, 32'd50);
    test_rotation(25, 66000, 400000);
    set_config(32'd37, 32'd200, 32'd500000, 32'd20);
    test_rotation(60, 1000, 20000);
    test_noise(60);
    test_rotation(40, 400000, 200000);
    drain();
    if (fail_count == 0 && expected_results.size() == 0)
      $display("slot_encoder_speed_meter regression: pass");
    else
      $display("slot_encoder_speed_meter regression: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("slot_encoder_speed_meter regression: fail");
    $finish;
  end

endmodule

/* slot_encoder_speed_meter.f */
sv/ssm_pkg.sv
sv/ssm_div.sv
sv/ssm_ctrl.sv
sv/ssm_datapath.sv
sv/slot_encoder_speed_meter.sv
verif/tb_slot_encoder_speed_meter.sv
